// ===== hdl/dccvl_pkg.sv =====
// Package for the DC charge vehicle link unit: payload structs, function codes,
// frame identifiers and protocol constants. No dependencies.

package dccvl_pkg;

  // Function codes carried in the func field of an input transaction
  localparam logic [2:0] FuncRx108  = 3'd0;
  localparam logic [2:0] FuncRx109  = 3'd1;
  localparam logic [2:0] FuncRamp   = 3'd2;
  localparam logic [2:0] FuncCheck  = 3'd3;
  localparam logic [2:0] FuncSend   = 3'd4;

  // Configuration register indexes
  localparam logic CfgChargeEnable = 1'b0;
  localparam logic CfgTargetVolt   = 1'b1;

  // Emitted frame identifiers
  localparam logic [8:0] IdStatus  = 9'h100;
  localparam logic [8:0] IdLimits  = 9'h101;
  localparam logic [8:0] IdRequest = 9'h102;

  // Protocol constants
  localparam logic [15:0] VtgDevLimit    = 16'd10;
  localparam logic [15:0] VtgMinVoltage  = 16'd50;
  localparam logic [8:0]  CurMargin      = 9'd12;
  localparam logic [7:0]  CurFaultLimit  = 8'd10;
  localparam logic [7:0]  VtgFaultLimit  = 8'd50;
  localparam logic [15:0] BatteryCap     = 16'd200;
  localparam logic [31:0] Frame101Low    = 32'h00FE_FF00;
  localparam logic [15:0] SocFixed       = 16'd100;
  localparam logic [7:0]  CountMax       = 8'hFF;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] rx_low_word;
    logic [7:0]  current_request;
    logic [15:0] internal_voltage;
    logic        parked;
    logic        vehicle_fault;
    logic        contactor_open;
  } in_item_t;

  typedef struct packed {
    logic [8:0]  frame_id;
    logic [31:0] frame_low_word;
    logic [31:0] frame_high_word;
    logic        last_frame;
  } out_item_t;

endpackage

// ===== hdl/dc_charge_vehicle_link_unit.sv =====
// DC charge vehicle link unit: charger frame decode, current ramp, fault
// timers and vehicle frame generation. Depends on dccvl_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one command per
//   transaction: decode charger frame 0x108 or 0x109, ramp step, deviation
//   check, or send. Decode, ramp and check act on internal state at the edge
//   that accepts them and produce no output transaction.
//   A send transaction captures a snapshot of the state and emits three output
//   transactions (frames 0x100, 0x101, 0x102, last_frame set on 0x102) on the
//   output channel (out_valid_o / out_stall_i / out_data_o), one per cycle
//   unless out_stall_i holds them. An accepted send sets the sequencer count
//   and snapshot, then the sequencer loads 0x100 into the output register.
//   Throughput: one command per cycle unless a send stalls. A send holds the
//   sequencer until its three frames are loaded; the next one is taken when
//   frame 0x102 is loaded, so back-to-back sends keep the output busy.
//   Non-send commands keep flowing while frames drain, since each frame is
//   built from the snapshot and not from live state.
//   Output stall: the output register holds its frame; the sequencer waits
//   and a pending send stalls. Configuration port (cfg_valid_i / cfg_ready_o)
//   is always ready; writing charge_enable as 0 clears ramp and fault counters.
//   Reset: state, counters and the sequencer clear; payload registers do not.

module dc_charge_vehicle_link_unit
  import dccvl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  // Configuration registers
  logic        charge_enable_q;
  logic [15:0] target_voltage_q;

  // Link state
  logic [7:0]  charger_max_current_q, charger_max_current_d;
  logic [1:0]  protocol_version_q, protocol_version_d;
  logic [15:0] charger_voltage_q, charger_voltage_d;
  logic [7:0]  charger_current_q, charger_current_d;
  logic [7:0]  ramped_current_q, ramped_current_d;
  logic [7:0]  voltage_fault_count_q, voltage_fault_count_d;
  logic [7:0]  current_fault_count_q, current_fault_count_d;

  // Frame sequencer: remaining frames and snapshot of the send run
  logic [1:0]  frames_left_q, frames_left_d;
  logic [15:0] snap_hi0_q;
  logic [31:0] snap_lo2_q;
  logic [31:0] snap_hi2_q;

  // Output register
  logic      out_valid_q, out_valid_d;
  out_item_t out_data_q, out_data_d;

  logic in_accept, cfg_accept, is_send, out_load;
  logic [7:0]  ramp_limit;
  logic [15:0] volt_dev;
  logic [8:0]  cur_threshold;
  logic        vtg_fault, cur_fault;
  logic [31:0] send_hi2;

  // Only a send must wait for the sequencer; everything else is taken at once.
  // A send may enter at the edge that loads the last frame of the current run.
  assign is_send     = (in_data_i.func == FuncSend);
  assign in_stall_o  = is_send && (frames_left_q != 2'd0) &&
                       !((frames_left_q == 2'd1) && out_load);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_accept  = cfg_valid_i && cfg_ready_o;

  // Datapath pieces for ramp and check
  assign ramp_limit = (in_data_i.current_request < charger_max_current_q) ?
                      in_data_i.current_request : charger_max_current_q;
  assign volt_dev   = (in_data_i.internal_voltage > charger_voltage_q) ?
                      (in_data_i.internal_voltage - charger_voltage_q) :
                      (charger_voltage_q - in_data_i.internal_voltage);
  assign cur_threshold = {1'b0, ramped_current_q} + CurMargin;

  assign cur_fault = (current_fault_count_q > CurFaultLimit);
  assign vtg_fault = (voltage_fault_count_q > VtgFaultLimit);
  assign send_hi2  = {SocFixed, 4'd0, in_data_i.contactor_open, in_data_i.vehicle_fault,
                      in_data_i.parked, charge_enable_q, 3'd0, vtg_fault, 1'b0,
                      cur_fault, 2'd0};

  // State update for one accepted transaction, then the disable clear on top
  always_comb begin
    charger_max_current_d = charger_max_current_q;
    protocol_version_d    = protocol_version_q;
    charger_voltage_d     = charger_voltage_q;
    charger_current_d     = charger_current_q;
    ramped_current_d      = ramped_current_q;
    voltage_fault_count_d = voltage_fault_count_q;
    current_fault_count_d = current_fault_count_q;
    if (in_accept) begin
      unique case (in_data_i.func)
        FuncRx108: begin
          charger_max_current_d = in_data_i.rx_low_word[31:24];
        end
        FuncRx109: begin
          protocol_version_d = in_data_i.rx_low_word[1:0];
          charger_voltage_d  = in_data_i.rx_low_word[23:8];
          charger_current_d  = in_data_i.rx_low_word[31:24];
        end
        FuncRamp: begin
          if (ramp_limit > ramped_current_q) begin
            ramped_current_d = ramped_current_q + 8'd1;
          end else if (ramp_limit < ramped_current_q) begin
            ramped_current_d = ramped_current_q - 8'd1;
          end
        end
        FuncCheck: begin
          // Count consecutive deviations, saturating at the counter maximum
          if ((volt_dev > VtgDevLimit) && (charger_voltage_q > VtgMinVoltage)) begin
            voltage_fault_count_d = (voltage_fault_count_q == CountMax) ?
                                    CountMax : voltage_fault_count_q + 8'd1;
          end else begin
            voltage_fault_count_d = '0;
          end
          if ({1'b0, charger_current_q} > cur_threshold) begin
            current_fault_count_d = (current_fault_count_q == CountMax) ?
                                    CountMax : current_fault_count_q + 8'd1;
          end else begin
            current_fault_count_d = '0;
          end
        end
        default: begin
          // Send is handled by the sequencer; unused codes do nothing.
        end
      endcase
    end
    if (cfg_accept && (cfg_index_i == CfgChargeEnable) && !cfg_data_i[0]) begin
      ramped_current_d      = '0;
      voltage_fault_count_d = '0;
      current_fault_count_d = '0;
    end
  end

  // Frame sequencer and output register: advance one frame whenever the
  // output register is empty or being drained.
  assign out_load = (frames_left_q != 2'd0) && (!out_valid_q || !out_stall_i);

  always_comb begin
    frames_left_d = frames_left_q;
    out_valid_d   = out_valid_q;
    out_data_d    = out_data_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d   = 1'b1;
      frames_left_d = frames_left_q - 2'd1;
      unique case (frames_left_q)
        2'd3: begin
          out_data_d.frame_id        = IdStatus;
          out_data_d.frame_low_word  = '0;
          out_data_d.frame_high_word = {BatteryCap, snap_hi0_q};
          out_data_d.last_frame      = 1'b0;
        end
        2'd2: begin
          out_data_d.frame_id        = IdLimits;
          out_data_d.frame_low_word  = Frame101Low;
          out_data_d.frame_high_word = '0;
          out_data_d.last_frame      = 1'b0;
        end
        default: begin
          out_data_d.frame_id        = IdRequest;
          out_data_d.frame_low_word  = snap_lo2_q;
          out_data_d.frame_high_word = snap_hi2_q;
          out_data_d.last_frame      = 1'b1;
        end
      endcase
    end
    if (in_accept && is_send) begin
      frames_left_d = 2'd3;
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      charge_enable_q       <= 1'b0;
      target_voltage_q      <= '0;
      charger_max_current_q <= '0;
      protocol_version_q    <= '0;
      charger_voltage_q     <= '0;
      charger_current_q     <= '0;
      ramped_current_q      <= '0;
      voltage_fault_count_q <= '0;
      current_fault_count_q <= '0;
      frames_left_q         <= '0;
      out_valid_q           <= 1'b0;
    end else begin
      if (cfg_accept) begin
        unique case (cfg_index_i)
          CfgChargeEnable: charge_enable_q  <= cfg_data_i[0];
          CfgTargetVolt:   target_voltage_q <= cfg_data_i;
          default: ;
        endcase
      end
      charger_max_current_q <= charger_max_current_d;
      protocol_version_q    <= protocol_version_d;
      charger_voltage_q     <= charger_voltage_d;
      charger_current_q     <= charger_current_d;
      ramped_current_q      <= ramped_current_d;
      voltage_fault_count_q <= voltage_fault_count_d;
      current_fault_count_q <= current_fault_count_d;
      frames_left_q         <= frames_left_d;
      out_valid_q           <= out_valid_d;
    end
  end

  // Payload registers: snapshot of the send run and the output frame
  always_ff @(posedge clk_i) begin
    if (in_accept && is_send) begin
      snap_hi0_q <= target_voltage_q + VtgDevLimit;
      snap_lo2_q <= {ramped_current_q, target_voltage_q, 6'd0, protocol_version_q};
      snap_hi2_q <= send_hi2;
    end
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  // A send enters only when the sequencer is idle or hands off its last frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && is_send) |->
      ((frames_left_q == 2'd0) || ((frames_left_q == 2'd1) && out_load)))
    else $error("send accepted while frame run still pending");

  // An accepted send arms the full three-frame run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && is_send) |=> (frames_left_q == 2'd3))
    else $error("send did not arm the frame sequencer");

  // The last frame of a run carries the last_frame flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (frames_left_q == 2'd1)) |=>
      (out_valid_o && out_data_o.last_frame && (out_data_o.frame_id == IdRequest)))
    else $error("final frame of run missing or mislabeled");

  // Frames leave in order: 0x101 always follows 0x100 on the next load.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (frames_left_q == 2'd2)) |=> (out_data_o.frame_id == IdLimits))
    else $error("frame 0x101 out of order");
`endif

endmodule
